### rtl/tlptw_pkg.sv
// Shared types and constants of the two-level page table walker.
package tlptw_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MMU_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_TABLE_BASE    = 2'd1;
    localparam logic [1:0] CFG_DOMAIN_ACCESS = 2'd2;

    // Request kinds
    localparam logic REQ_TRANSLATE  = 1'b0;
    localparam logic REQ_DESCRIPTOR = 1'b1;

    // Result kinds
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // Completion status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SECT_XLAT   = 3'd1;
    localparam logic [2:0] ST_PAGE_XLAT   = 3'd2;
    localparam logic [2:0] ST_SECT_DOMAIN = 3'd3;
    localparam logic [2:0] ST_PAGE_DOMAIN = 3'd4;
    localparam logic [2:0] ST_SECT_PERM   = 3'd5;
    localparam logic [2:0] ST_PAGE_PERM   = 3'd6;

    // Descriptor type codes in bits 1:0
    localparam logic [1:0] L1_FAULT   = 2'd0;
    localparam logic [1:0] L1_COARSE  = 2'd1;
    localparam logic [1:0] L1_SECTION = 2'd2;
    localparam logic [1:0] L2_FAULT   = 2'd0;
    localparam logic [1:0] L2_LARGE   = 2'd1;

    // Domain access modes
    localparam logic [1:0] DOM_NONE     = 2'd0;
    localparam logic [1:0] DOM_CLIENT   = 2'd1;
    localparam logic [1:0] DOM_RESERVED = 2'd2;
    localparam logic [1:0] DOM_MANAGER  = 2'd3;

    localparam logic [31:0] FAULT_CANARY = 32'hf0f0f0f0;

    // Fault status nibbles
    localparam logic [3:0] FSR_SECT_XLAT   = 4'h5;
    localparam logic [3:0] FSR_PAGE_XLAT   = 4'h7;
    localparam logic [3:0] FSR_SECT_DOMAIN = 4'h9;
    localparam logic [3:0] FSR_PAGE_DOMAIN = 4'hb;
    localparam logic [3:0] FSR_SECT_PERM   = 4'hd;
    localparam logic [3:0] FSR_PAGE_PERM   = 4'hf;
    localparam logic [3:0] FSR_NONE        = 4'h0;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_L1   = 3'b010,
        PH_L2   = 3'b100
    } phase_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] lookup_va;
        logic        priv_access;
        logic        wr_access;
        logic        ifetch_access;
        logic        side_effects;
        logic [31:0] descriptor_data;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] read_addr;
        logic [31:0] xlat_pa;
        logic [2:0]  status;
        logic        fault_report;
        logic        fault_is_fetch;
        logic [11:0] fault_status;
        logic [31:0] fault_address;
    } rsp_t;

    // Access flags of the request being walked
    typedef struct packed {
        logic side_effects;
        logic fetch;
        logic write;
        logic kernel;
    } flags_t;

endpackage

### rtl/two_level_page_table_walk_core.sv
// Top level of the two-level short-descriptor page table walker.
// The result of an accepted request is held in the output register from the next cycle.
// Throughput: one request per cycle; the only hold-up is a full output register
// whose result is stalled, since the decode and permission check sit in one stage.
// Reset: rst_n clears the configuration registers, the walk phase (idle) and the
// output valid bit at once; no clearing pass is needed.
module two_level_page_table_walk_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tlptw_pkg::req_t   in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output tlptw_pkg::rsp_t   out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata
);
    import tlptw_pkg::*;

    // Configuration registers
    logic        mmu_enable_reg;
    logic [31:0] table_base_reg;
    logic [31:0] domain_access_reg;

    // Walk state, carried between a request and its descriptor words
    phase_t      phase_reg, phase_next;
    logic [31:0] vaddr_reg, vaddr_next;
    flags_t      flags_reg, flags_next;
    logic [3:0]  domain_reg, domain_next;

    // Output register: it parts the two sides so that a new request can be
    // accepted in the same cycle as the waiting result is taken.
    logic        out_valid_reg;
    rsp_t        out_data_reg;

    logic        in_accept;
    logic        res_valid;
    rsp_t        res;

    // Completion fields before they are folded into a result
    logic        done;
    logic [2:0]  done_status;
    logic [31:0] done_pa;
    logic [31:0] rd_addr;
    logic [31:0] d;
    logic [1:0]  dom_mode;
    logic        perm_ok;
    logic [2:0]  ap;
    logic        xn;
    logic [3:0]  fsr_code;

    // AP/APX and XN check for a client domain.
    function automatic logic access_ok(input logic [2:0] ap_in, input logic xn_in,
                                       input flags_t f);
        logic ok;
        begin
            ok = 1'b0;
            case (ap_in)
                3'd1:          ok = f.kernel;
                3'd2:          ok = f.kernel || !f.write;
                3'd3:          ok = 1'b1;
                3'd5:          ok = f.kernel && !f.write;
                3'd6, 3'd7:    ok = !f.write;
                default:       ok = 1'b0;
            endcase
            if (f.fetch && xn_in)
            begin
                ok = 1'b0;
            end
            return ok;
        end
    endfunction

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign d         = in_data.descriptor_data;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mmu_enable_reg    <= 1'b0;
            table_base_reg    <= '0;
            domain_access_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MMU_ENABLE:    mmu_enable_reg    <= cfg_wdata[0];
                CFG_TABLE_BASE:    table_base_reg    <= cfg_wdata;
                CFG_DOMAIN_ACCESS: domain_access_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Decode of one request or descriptor word against the walk state.
    always_comb
    begin
        phase_next  = phase_reg;
        vaddr_next  = vaddr_reg;
        flags_next  = flags_reg;
        domain_next = domain_reg;
        res_valid   = 1'b0;
        done        = 1'b0;
        done_status = ST_OK;
        done_pa     = '0;
        rd_addr     = '0;
        ap          = '0;
        xn          = 1'b0;
        dom_mode    = DOM_NONE;
        perm_ok     = 1'b0;

        if (in_data.req_type == REQ_TRANSLATE)
        begin
            // A new request always restarts the walk, even in the middle of one.
            vaddr_next  = in_data.lookup_va;
            flags_next  = '{side_effects: in_data.side_effects, fetch: in_data.ifetch_access,
                            write: in_data.wr_access, kernel: in_data.priv_access};
            domain_next = '0;
            res_valid   = 1'b1;
            if (!mmu_enable_reg)
            begin
                phase_next = PH_IDLE;
                done       = 1'b1;
                done_pa    = in_data.lookup_va;
            end
            else
            begin
                phase_next = PH_L1;
                rd_addr    = {table_base_reg[31:14], in_data.lookup_va[31:20], 2'b00};
            end
        end
        else
        begin
            phase_next = PH_IDLE;
            unique case (phase_reg)
                PH_L1:
                begin
                    res_valid = 1'b1;
                    case (d[1:0])
                        L1_COARSE:
                        begin
                            domain_next = d[8:5];
                            phase_next  = PH_L2;
                            rd_addr     = {d[31:10], vaddr_reg[19:12], 2'b00};
                        end
                        L1_SECTION:
                        begin
                            domain_next = d[8:5];
                            done        = 1'b1;
                            dom_mode    = domain_access_reg[{d[8:5], 1'b0} +: 2];
                            ap          = {d[15], d[11:10]};
                            xn          = d[4];
                            perm_ok     = access_ok(ap, xn, flags_reg);
                            if (dom_mode == DOM_NONE || dom_mode == DOM_RESERVED)
                            begin
                                done_status = ST_SECT_DOMAIN;
                            end
                            else if (dom_mode == DOM_CLIENT && !perm_ok)
                            begin
                                done_status = ST_SECT_PERM;
                            end
                            else
                            begin
                                done_pa = {d[31:20], vaddr_reg[19:0]};
                            end
                        end
                        default:
                        begin
                            // Fault descriptor and the unused type both fault here.
                            domain_next = '0;
                            done        = 1'b1;
                            done_status = ST_SECT_XLAT;
                        end
                    endcase
                end
                PH_L2:
                begin
                    res_valid = 1'b1;
                    done      = 1'b1;
                    dom_mode  = domain_access_reg[{domain_reg, 1'b0} +: 2];
                    ap        = {d[9], d[5:4]};
                    xn        = (d[1:0] == L2_LARGE) ? d[15] : d[0];
                    perm_ok   = access_ok(ap, xn, flags_reg);
                    if (d[1:0] == L2_FAULT)
                    begin
                        done_status = ST_PAGE_XLAT;
                    end
                    else if (dom_mode == DOM_NONE || dom_mode == DOM_RESERVED)
                    begin
                        done_status = ST_PAGE_DOMAIN;
                    end
                    else if (dom_mode == DOM_CLIENT && !perm_ok)
                    begin
                        done_status = ST_PAGE_PERM;
                    end
                    else if (d[1:0] == L2_LARGE)
                    begin
                        done_pa = {d[31:16], vaddr_reg[15:0]};
                    end
                    else
                    begin
                        done_pa = {d[31:12], vaddr_reg[11:0]};
                    end
                end
                default:
                begin
                    // A descriptor word with no walk in progress is dropped.
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (done_status)
            ST_SECT_XLAT:   fsr_code = FSR_SECT_XLAT;
            ST_PAGE_XLAT:   fsr_code = FSR_PAGE_XLAT;
            ST_SECT_DOMAIN: fsr_code = FSR_SECT_DOMAIN;
            ST_PAGE_DOMAIN: fsr_code = FSR_PAGE_DOMAIN;
            ST_SECT_PERM:   fsr_code = FSR_SECT_PERM;
            ST_PAGE_PERM:   fsr_code = FSR_PAGE_PERM;
            default:        fsr_code = FSR_NONE;
        endcase
    end

    // Fold the decode into one result. The fault fields use the flags and
    // domain as they stand after this step, which is what the status word reports.
    always_comb
    begin
        res = '0;
        if (!done)
        begin
            res.result_kind = RES_READ;
            res.read_addr   = rd_addr;
        end
        else
        begin
            res.result_kind = RES_DONE;
            res.status      = done_status;
            res.xlat_pa     = (done_status != ST_OK) ? FAULT_CANARY : done_pa;
            if (done_status != ST_OK && flags_next.side_effects)
            begin
                res.fault_report   = 1'b1;
                res.fault_is_fetch = flags_next.fetch;
                res.fault_address  = vaddr_next;
                res.fault_status   = {flags_next.write, 3'b000,
                                      flags_next.fetch ? 4'h0 : domain_next, fsr_code};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            vaddr_reg     <= '0;
            flags_reg     <= '0;
            domain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                vaddr_reg  <= vaddr_next;
                flags_reg  <= flags_next;
                domain_reg <= domain_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= res_valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A translation request with the unit enabled opens a first-level read.
    a_l1_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.req_type == REQ_TRANSLATE && mmu_enable_reg)
        |=> (phase_reg == PH_L1 && out_valid && out_data.result_kind == RES_READ))
        else $error("translation request did not start a first-level read");

    // The second-level word always ends the walk with a finished result.
    a_l2_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.req_type == REQ_DESCRIPTOR && phase_reg == PH_L2)
        |=> (phase_reg == PH_IDLE && out_valid && out_data.result_kind == RES_DONE))
        else $error("second-level descriptor did not finish the walk");

    // Faulted results carry the canary address; good ones never report a fault.
    a_fault_canary: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.result_kind == RES_DONE && out_data.status != ST_OK)
        |-> (out_data.xlat_pa == FAULT_CANARY))
        else $error("faulted translation without canary address");

    a_no_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_OK) |-> !out_data.fault_report)
        else $error("fault reported on a successful result");

endmodule
